// ===== rtl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Types, constants and helpers shared by the two-wheel sync drive controller.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int TICK_BITS = 32;
    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF >> (32 - TICK_BITS);

    // request kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 31;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_TARGET  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_TARGET = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TICK_TARGET  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_PERIOD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_TICKS    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_TOL     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CHANGE   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAUSE_MS     = 3'd7;

    // register reset values
    localparam logic signed [7:0] RST_TARGET_POWER = 8'sd50;
    localparam logic [30:0] RST_TICK_TARGET  = 31'd0;
    localparam logic [15:0] RST_CHECK_PERIOD = 16'd250;
    localparam logic [15:0] RST_MIN_TICKS    = 16'd36;
    localparam logic [15:0] RST_SYNC_TOL     = 16'd5;
    localparam logic [6:0]  RST_MAX_CHANGE   = 7'd10;
    localparam logic [15:0] RST_PAUSE_MS     = 16'd500;

    typedef logic [TICK_BITS-1:0] t_tick;

    typedef struct packed {
        logic signed [7:0] left_target_power;
        logic signed [7:0] right_target_power;
        logic [30:0]       tick_target;
        logic [15:0]       check_period_ms;
        logic [15:0]       stall_min_ticks;
        logic [15:0]       sync_tolerance;
        logic [6:0]        trim_limit;
        logic [15:0]       stall_pause_ms;
    } t_cfg;

    // request after the input register, tick counts already as magnitudes
    typedef struct packed {
        logic        kind;
        logic [31:0] time_ms;
        t_tick       left_mag;
        t_tick       right_mag;
    } t_item;

    typedef struct packed {
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic              move_done;
        logic              stall_pausing;
    } t_result;

    // |count| saturated to the tick range
    function automatic t_tick tick_mag(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return (m > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0] : m[TICK_BITS-1:0];
    endfunction

    // magnitude of a target power, 0..128
    function automatic logic [7:0] power_abs(input logic signed [7:0] p);
        return p[7] ? (8'd0 - 8'(p)) : 8'(p);
    endfunction

    function automatic logic signed [7:0] drive_val(input logic [6:0] p, input logic rev);
        return rev ? $signed(8'd0 - {1'b0, p}) : $signed({1'b0, p});
    endfunction

endpackage

// ===== rtl/tsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// tsd_in_stage
// Input register: captures a request and folds the encoder counts into
// saturated magnitudes on the way in.
// ----------------------------------------------------------------------------
module tsd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  logic [31:0]        i_time_ms,
    input  logic signed [31:0] i_left_ticks,
    input  logic signed [31:0] i_right_ticks,
    input  logic               i_advance,
    output logic               o_in_stall,
    output logic               o_item_valid,
    output tsd_pkg::t_item     o_item
);
    import tsd_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind      <= i_kind;
            r_item.time_ms   <= i_time_ms;
            r_item.left_mag  <= tick_mag(i_left_ticks);
            r_item.right_mag <= tick_mag(i_right_ticks);
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== rtl/tsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsd_ctrl
// Move state and the per-request decision: completion, pause, periodic stall
// and sync check, drive outputs.
// ----------------------------------------------------------------------------
module tsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  tsd_pkg::t_item   i_item,
    input  tsd_pkg::t_cfg    i_cfg,
    output tsd_pkg::t_result o_result
);
    import tsd_pkg::*;

    logic [6:0]  r_left_power, n_left_power;
    logic [6:0]  r_right_power, n_right_power;
    logic        r_left_rev, n_left_rev;
    logic        r_right_rev, n_right_rev;
    logic [31:0] r_next_check, n_next_check;
    t_tick       r_prev_left, n_prev_left;
    t_tick       r_prev_right, n_prev_right;
    logic [31:0] r_pause_end, n_pause_end;
    logic        r_pausing, n_pausing;
    logic        r_moving, n_moving;

    logic [7:0]  left_abs, right_abs;
    logic [6:0]  left_start_pow, right_start_pow;
    logic [31:0] lt32, rt32, tgt32;
    logic        left_done, right_done;
    logic [31:0] pause_diff, check_diff;
    logic        pause_over, check_due;
    t_tick       left_moved, right_moved, tick_diff;
    logic        left_driven, right_driven, stalled;
    logic        slow_is_left;
    logic [6:0]  slow_pow, fast_pow;
    logic [7:0]  slow_abs, fast_abs;
    logic [8:0]  up_limit;
    logic signed [9:0] dn_limit;
    logic        can_raise, can_lower;
    logic [6:0]  slow_new, fast_new;
    logic [31:0] now_plus_period;
    logic [31:0] pause_end_new;
    logic [31:0] pause_check;

    assign left_abs        = power_abs(i_cfg.left_target_power);
    assign right_abs       = power_abs(i_cfg.right_target_power);
    assign left_start_pow  = left_abs[7] ? 7'd127 : left_abs[6:0];
    assign right_start_pow = right_abs[7] ? 7'd127 : right_abs[6:0];

    assign lt32       = 32'(i_item.left_mag);
    assign rt32       = 32'(i_item.right_mag);
    assign tgt32      = {1'b0, i_cfg.tick_target};
    assign left_done  = lt32 >= tgt32;
    assign right_done = rt32 >= tgt32;

    // wrap-safe time compares
    assign pause_diff = i_item.time_ms - r_pause_end;
    assign check_diff = i_item.time_ms - r_next_check;
    assign pause_over = !pause_diff[31];
    assign check_due  = (check_diff != 32'd0) && !check_diff[31];

    assign left_moved  = (i_item.left_mag >= r_prev_left) ? i_item.left_mag - r_prev_left
                                                          : r_prev_left - i_item.left_mag;
    assign right_moved = (i_item.right_mag >= r_prev_right) ? i_item.right_mag - r_prev_right
                                                            : r_prev_right - i_item.right_mag;
    assign tick_diff   = (i_item.left_mag >= i_item.right_mag)
                         ? i_item.left_mag - i_item.right_mag
                         : i_item.right_mag - i_item.left_mag;

    assign left_driven  = !left_done && (r_left_power != 7'd0);
    assign right_driven = !right_done && (r_right_power != 7'd0);
    assign stalled = (left_driven && (32'(left_moved) < 32'(i_cfg.stall_min_ticks))) ||
                     (right_driven && (32'(right_moved) < 32'(i_cfg.stall_min_ticks)));

    // sync nudge: raise the slower wheel first, then lower the faster one
    assign slow_is_left = i_item.left_mag < i_item.right_mag;
    assign slow_pow     = slow_is_left ? r_left_power : r_right_power;
    assign fast_pow     = slow_is_left ? r_right_power : r_left_power;
    assign slow_abs     = slow_is_left ? left_abs : right_abs;
    assign fast_abs     = slow_is_left ? right_abs : left_abs;
    assign up_limit     = {1'b0, slow_abs} + {2'b00, i_cfg.trim_limit};
    assign dn_limit     = $signed({2'b00, fast_abs}) - $signed({3'b000, i_cfg.trim_limit});
    assign can_raise    = {2'b00, slow_pow} < up_limit;
    assign can_lower    = $signed({3'b000, fast_pow}) > dn_limit;

    always_comb begin
        slow_new = slow_pow;
        fast_new = fast_pow;
        if (can_raise) begin
            if (slow_pow != 7'd127) begin
                slow_new = slow_pow + 7'd1;
            end
        end else if (can_lower) begin
            if (fast_pow != 7'd0) begin
                fast_new = fast_pow - 7'd1;
            end
        end
    end

    assign now_plus_period = i_item.time_ms + 32'(i_cfg.check_period_ms);
    assign pause_end_new   = i_item.time_ms + 32'(i_cfg.stall_pause_ms);
    assign pause_check     = i_item.time_ms
                             + 32'({1'b0, i_cfg.stall_pause_ms} + {1'b0, i_cfg.check_period_ms});

    always_comb begin
        logic pause_now;
        n_left_power  = r_left_power;
        n_right_power = r_right_power;
        n_left_rev    = r_left_rev;
        n_right_rev   = r_right_rev;
        n_next_check  = r_next_check;
        n_prev_left   = r_prev_left;
        n_prev_right  = r_prev_right;
        n_pause_end   = r_pause_end;
        n_pausing     = r_pausing;
        n_moving      = r_moving;
        o_result      = '0;
        pause_now     = r_pausing && !pause_over;

        if (i_item.kind == KIND_START) begin
            n_left_power  = left_start_pow;
            n_right_power = right_start_pow;
            n_left_rev    = i_cfg.left_target_power[7];
            n_right_rev   = i_cfg.right_target_power[7];
            n_prev_left   = '0;
            n_prev_right  = '0;
            n_next_check  = now_plus_period;
            n_pausing     = 1'b0;
            if (i_cfg.tick_target == 31'd0) begin
                n_moving           = 1'b0;
                o_result.move_done = 1'b1;
            end else begin
                n_moving             = 1'b1;
                o_result.left_drive  = drive_val(left_start_pow, i_cfg.left_target_power[7]);
                o_result.right_drive = drive_val(right_start_pow, i_cfg.right_target_power[7]);
            end
        end else if (r_moving) begin
            if (left_done && right_done) begin
                n_moving           = 1'b0;
                n_pausing          = 1'b0;
                o_result.move_done = 1'b1;
            end else begin
                n_pausing = pause_now;
                if (!pause_now && check_due) begin
                    if (tick_diff > 32'(i_cfg.sync_tolerance)) begin
                        if (slow_is_left) begin
                            n_left_power  = slow_new;
                            n_right_power = fast_new;
                        end else begin
                            n_right_power = slow_new;
                            n_left_power  = fast_new;
                        end
                    end
                    n_prev_left  = i_item.left_mag;
                    n_prev_right = i_item.right_mag;
                    n_next_check = now_plus_period;
                    if (stalled) begin
                        n_pausing    = 1'b1;
                        n_pause_end  = pause_end_new;
                        n_next_check = pause_check;
                    end
                end
                if (n_pausing) begin
                    o_result.stall_pausing = 1'b1;
                end else begin
                    if (!left_done) begin
                        o_result.left_drive = drive_val(n_left_power, r_left_rev);
                    end
                    if (!right_done) begin
                        o_result.right_drive = drive_val(n_right_power, r_right_rev);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_power  <= '0;
            r_right_power <= '0;
            r_left_rev    <= 1'b0;
            r_right_rev   <= 1'b0;
            r_next_check  <= '0;
            r_prev_left   <= '0;
            r_prev_right  <= '0;
            r_pause_end   <= '0;
            r_pausing     <= 1'b0;
            r_moving      <= 1'b0;
        end else if (i_fire) begin
            r_left_power  <= n_left_power;
            r_right_power <= n_right_power;
            r_left_rev    <= n_left_rev;
            r_right_rev   <= n_right_rev;
            r_next_check  <= n_next_check;
            r_prev_left   <= n_prev_left;
            r_prev_right  <= n_prev_right;
            r_pause_end   <= n_pause_end;
            r_pausing     <= n_pausing;
            r_moving      <= n_moving;
        end
    end

endmodule

// ===== rtl/two_wheel_sync_drive_controller_core.sv =====
// a request is held in the input register, then in the result register once the pipeline advances
// throughput: one request per cycle while the result side takes results
// the input register and the result register each hold one request
// reset (synchronous, active low): registers back to defaults, no move
// in progress, both pipeline registers empty
// ----------------------------------------------------------------------------
// two_wheel_sync_drive_controller_core
// Two-wheel drive controller: tick target, stall pause and left-right sync.
// ----------------------------------------------------------------------------
module two_wheel_sync_drive_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [31:0]                   i_time_ms,
    input  logic signed [31:0]            i_left_ticks,
    input  logic signed [31:0]            i_right_ticks,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [7:0]             o_left_drive,
    output logic signed [7:0]             o_right_drive,
    output logic                          o_move_done,
    output logic                          o_stall_pausing
);
    import tsd_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    t_result result;
    t_result r_result;
    logic    r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_target_power   <= RST_TARGET_POWER;
            r_cfg.right_target_power  <= RST_TARGET_POWER;
            r_cfg.tick_target         <= RST_TICK_TARGET;
            r_cfg.check_period_ms     <= RST_CHECK_PERIOD;
            r_cfg.stall_min_ticks     <= RST_MIN_TICKS;
            r_cfg.sync_tolerance      <= RST_SYNC_TOL;
            r_cfg.trim_limit          <= RST_MAX_CHANGE;
            r_cfg.stall_pause_ms      <= RST_PAUSE_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEFT_TARGET:  r_cfg.left_target_power   <= $signed(i_cfg_data[7:0]);
                REG_RIGHT_TARGET: r_cfg.right_target_power  <= $signed(i_cfg_data[7:0]);
                REG_TICK_TARGET:  r_cfg.tick_target         <= i_cfg_data[30:0];
                REG_CHECK_PERIOD: r_cfg.check_period_ms     <= i_cfg_data[15:0];
                REG_MIN_TICKS:    r_cfg.stall_min_ticks     <= i_cfg_data[15:0];
                REG_SYNC_TOL:     r_cfg.sync_tolerance      <= i_cfg_data[15:0];
                REG_MAX_CHANGE:   r_cfg.trim_limit          <= i_cfg_data[6:0];
                REG_PAUSE_MS:     r_cfg.stall_pause_ms      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline moves when the result register is free or being taken
    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = item_valid && advance;

    tsd_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_kind        (i_kind),
        .i_time_ms     (i_time_ms),
        .i_left_ticks  (i_left_ticks),
        .i_right_ticks (i_right_ticks),
        .i_advance     (advance),
        .o_in_stall    (o_in_stall),
        .o_item_valid  (item_valid),
        .o_item        (item)
    );

    tsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_drive    = r_result.left_drive;
    assign o_right_drive   = r_result.right_drive;
    assign o_move_done     = r_result.move_done;
    assign o_stall_pausing = r_result.stall_pausing;

endmodule

// ===== rtl/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks for the two-wheel sync drive controller.
// ----------------------------------------------------------------------------
module tsd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic signed [7:0] o_left_drive,
    input logic signed [7:0] o_right_drive,
    input logic              o_move_done,
    input logic              o_stall_pausing
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_drive)
            && $stable(o_right_drive) && $stable(o_move_done) && $stable(o_stall_pausing))
        else $error("result changed while stalled");

    // a paused move drives nothing
    a_pause_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stall_pausing |-> o_left_drive == 8'sd0 && o_right_drive == 8'sd0)
        else $error("drive applied during stall pause");

    // a finished move drives nothing and is not paused
    a_done_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_move_done |-> o_left_drive == 8'sd0 && o_right_drive == 8'sd0
            && !o_stall_pausing)
        else $error("drive or pause flagged on finished move");

    // requests are only held back while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind two_wheel_sync_drive_controller_core tsd_checker u_tsd_checker (.*);
